### src/w26_pkg.sv
// ---------------------------------------------------------------------------
// w26_pkg: shared types and constants for the Wiegand 26-bit transmitter
// Transaction payload structs, configuration register codes and reset values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package w26_pkg;

	// Fixed field widths
	localparam int CARD_BITS = 24;
	localparam int TICK_W    = 16;
	localparam int CFG_IDX_W = 2;

	// Register reset values
	localparam logic [TICK_W-1:0] PULSE_TICKS_RST = 16'd100;
	localparam logic [TICK_W-1:0] GAP_TICKS_RST   = 16'd1500;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PULSE_TICKS   = 2'd0,
		CFG_GAP_TICKS     = 2'd1,
		CFG_PARITY_INVERT = 2'd2
	} w26_cfg_idx_t;

	// Action codes
	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_START = 1'b1;

	// Input transaction
	typedef struct packed {
		logic                 action;
		logic [CARD_BITS-1:0] card_data;
	} w26_in_t;

	// Result transaction
	typedef struct packed {
		logic data0_line;
		logic data1_line;
		logic busy_res;
		logic frame_done;
	} w26_out_t;

	// Register file contents
	typedef struct packed {
		logic [TICK_W-1:0] pulse_ticks;
		logic [TICK_W-1:0] gap_ticks;
		logic              parity_invert;
	} w26_cfg_t;

endpackage

### src/w26_frame.sv
// ---------------------------------------------------------------------------
// w26_frame: frame builder
// Forms the data-plus-parity frame from a card number, lead parity bit on top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module w26_frame import w26_pkg::*; #(
	parameter int DATA_BITS = 24
) (
	input  logic [CARD_BITS-1:0]   card_data,
	input  logic                   parity_invert,
	output logic [DATA_BITS+1:0]   frame
);

	localparam int LOW_HALF = DATA_BITS / 2;

	logic [DATA_BITS-1:0] data;
	logic                 lead;
	logic                 trail;

	// Upper half gets even parity, lower half odd parity
	always_comb begin
		data  = DATA_BITS'(card_data);
		lead  = (^data[DATA_BITS-1:LOW_HALF]) ^ parity_invert;
		trail = ~(^data[LOW_HALF-1:0]) ^ parity_invert;
		frame = {lead, data, trail};
	end

endmodule

### src/w26_seq.sv
// ---------------------------------------------------------------------------
// w26_seq: bit sequencer
// Holds the frame shifter, phase timer and bit counter; computes the line
// levels for each accepted transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module w26_seq import w26_pkg::*; #(
	parameter int DATA_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  w26_in_t              item,
	input  w26_cfg_t             cfg,
	input  logic [DATA_BITS+1:0] frame,
	output w26_out_t             result
);

	localparam int FRAME_BITS = DATA_BITS + 2;
	localparam int CNT_W      = $clog2(FRAME_BITS + 1);

	logic [FRAME_BITS-1:0] frame_shift_q, frame_shift_n;
	logic [CNT_W-1:0]      bits_left_q, bits_left_n;
	logic                  in_pulse_q, in_pulse_n;
	logic [TICK_W-1:0]     phase_timer_q, phase_timer_n;
	logic                  sending_q, sending_n;
	logic                  done;
	logic [TICK_W-1:0]     pulse_load;
	logic [TICK_W-1:0]     gap_load;

	// A zero timing register counts as one tick
	assign pulse_load = (cfg.pulse_ticks == '0) ? TICK_W'(1) : cfg.pulse_ticks;
	assign gap_load   = (cfg.gap_ticks == '0) ? TICK_W'(1) : cfg.gap_ticks;

	// Next state for one transaction
	always_comb begin
		frame_shift_n = frame_shift_q;
		bits_left_n   = bits_left_q;
		in_pulse_n    = in_pulse_q;
		phase_timer_n = phase_timer_q;
		sending_n     = sending_q;
		done          = 1'b0;
		if (item.action == ACT_START) begin
			// start while busy is dropped
			if (!sending_q) begin
				frame_shift_n = frame;
				bits_left_n   = CNT_W'(FRAME_BITS);
				in_pulse_n    = 1'b1;
				phase_timer_n = pulse_load;
				sending_n     = 1'b1;
			end
		end else if (sending_q) begin
			phase_timer_n = phase_timer_q - TICK_W'(1);
			if (phase_timer_q == TICK_W'(1)) begin
				if (in_pulse_q) begin
					in_pulse_n    = 1'b0;
					phase_timer_n = gap_load;
				end else begin
					frame_shift_n = {frame_shift_q[FRAME_BITS-2:0], 1'b0};
					bits_left_n   = bits_left_q - CNT_W'(1);
					if (bits_left_q == CNT_W'(1)) begin
						sending_n = 1'b0;
						done      = 1'b1;
					end else begin
						in_pulse_n    = 1'b1;
						phase_timer_n = pulse_load;
					end
				end
			end
		end
	end

	// Line levels after the step
	always_comb begin
		result.data0_line = !(sending_n && in_pulse_n && !frame_shift_n[FRAME_BITS-1]);
		result.data1_line = !(sending_n && in_pulse_n && frame_shift_n[FRAME_BITS-1]);
		result.busy_res   = sending_n;
		result.frame_done = done;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_shift_q <= '0;
			bits_left_q   <= '0;
			in_pulse_q    <= 1'b0;
			phase_timer_q <= '0;
			sending_q     <= 1'b0;
		end else if (step_en) begin
			frame_shift_q <= frame_shift_n;
			bits_left_q   <= bits_left_n;
			in_pulse_q    <= in_pulse_n;
			phase_timer_q <= phase_timer_n;
			sending_q     <= sending_n;
		end
	end

endmodule

### src/w26_out_buf.sv
// ---------------------------------------------------------------------------
// w26_out_buf: result register with skid stage
// Holds results until taken; the skid entry absorbs one transaction while the
// output is stalled so the input side keeps moving.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module w26_out_buf import w26_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  w26_out_t push_data,
	output logic     full,
	output logic     out_valid,
	input  logic     out_stall,
	output w26_out_t out_data
);

	logic     out_valid_q;
	w26_out_t out_data_q;
	logic     skid_valid_q;
	w26_out_t skid_data_q;
	logic     out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

endmodule

### src/wiegand_26_transmitter.sv
// ---------------------------------------------------------------------------
// wiegand_26_transmitter: Wiegand 26-bit frame transmitter
// Sends a card number as lead parity, data MSB first and trail parity, one
// low pulse per bit on DATA1 or DATA0, timed in tick transactions.
// ---------------------------------------------------------------------------
// Each input transaction (a tick or a start) yields exactly one result
// transaction with the line levels, busy flag and frame-done flag after that
// step. The block takes one transaction per clock while in_stall is low; the
// sequencer state updates in the cycle of acceptance; the output buffer
// registers the result. A two-entry output (result register plus skid entry)
// lets input keep flowing for one more transaction while the output is
// stalled; in_stall rises only when both entries hold results. Write the
// timing and parity registers only while all results are out; a timing value
// written during a frame is picked up at the next pulse or gap load.
`timescale 1ns / 1ps

module wiegand_26_transmitter import w26_pkg::*; #(
	parameter int DATA_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  w26_in_t              in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output w26_out_t             out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data
);

	w26_cfg_t             cfg_q;
	logic [DATA_BITS+1:0] frame;
	logic                 in_acc;
	w26_out_t             result;
	logic                 buf_full;

	assign in_stall = buf_full;
	assign in_acc   = in_valid && !buf_full;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_ticks   <= PULSE_TICKS_RST;
			cfg_q.gap_ticks     <= GAP_TICKS_RST;
			cfg_q.parity_invert <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PULSE_TICKS:   cfg_q.pulse_ticks   <= cfg_data;
				CFG_GAP_TICKS:     cfg_q.gap_ticks     <= cfg_data;
				CFG_PARITY_INVERT: cfg_q.parity_invert <= cfg_data[0];
				default: ;
			endcase
		end
	end

	w26_frame #(.DATA_BITS(DATA_BITS)) u_frame (
		.card_data     (in_data.card_data),
		.parity_invert (cfg_q.parity_invert),
		.frame         (frame)
	);

	w26_seq #(.DATA_BITS(DATA_BITS)) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (in_acc),
		.item    (in_data),
		.cfg     (cfg_q),
		.frame   (frame),
		.result  (result)
	);

	w26_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_acc),
		.push_data (result),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

### src/w26_checker.sv
// ---------------------------------------------------------------------------
// w26_checker: port-level checks for the Wiegand transmitter
// Watches the result channel for line-level and completion consistency.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module w26_checker import w26_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     out_valid,
	input logic     out_stall,
	input w26_out_t out_data
);

	// Stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Never pulse both lines at once
	a_one_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.data0_line || out_data.data1_line))
		else $error("both data lines low");

	// Idle means both lines high
	a_idle_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.busy_res |-> (out_data.data0_line && out_data.data1_line))
		else $error("line low while idle");

	// Frame completion ends busy
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_done |-> !out_data.busy_res)
		else $error("frame done while still busy");

endmodule

bind wiegand_26_transmitter w26_checker u_w26_checker (.*);
